// File: rtl/lidar_reactive_steering_defines.svh
// Assertion macros for the lidar reactive steering block.
// Included by the top level; no other dependencies.
`ifndef LIDAR_REACTIVE_STEERING_DEFINES_SVH
`define LIDAR_REACTIVE_STEERING_DEFINES_SVH
`ifndef ASSERT_OFF
`define LRS_ASSERT_SAME(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("lrs: assertion failed");
`define LRS_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("lrs: assertion failed");
`else
`define LRS_ASSERT_SAME(lbl, clk, rstn, pre, post)
`define LRS_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

// File: rtl/lrs_pkg.sv
// Shared types, constants and lookup tables for the lidar reactive steering block.
// No dependencies.
`default_nettype none
package lrs_pkg;

    localparam int PI_Q13        = 25736;
    localparam int HALF_PI_Q13   = 12868;
    localparam int TWO_PI_Q13    = 51472;
    localparam int ONE_Q14       = 16384;
    localparam int CORDIC_X0     = 9949;
    localparam int NEAREST_RESET = 1280;
    localparam int SIG_SAT_RANGE = 2048;  // 8 m in Q8.8
    localparam int RED_STEPS     = 11;    // 2pi multiples 2^10 .. 2^0
    localparam int CORDIC_STEPS  = 14;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORRIDOR_HALF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROBOT_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_DEADBAND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_DEADBAND   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_LIMIT      = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE, ST_ANG, ST_RED, ST_FOLD, ST_ROT, ST_SC, ST_MCC, ST_MSS, ST_MINT,
        ST_MDW, ST_W, ST_MSW, ST_MCW, ST_MCOR, ST_UPD, ST_VINIT, ST_VEC, ST_FIN,
        ST_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ANG, OP_RED, OP_FOLD, OP_ROT, OP_SC, OP_MCC, OP_MSS,
        OP_MINT, OP_MDW, OP_W, OP_MSW, OP_MCW, OP_MCOR, OP_UPD, OP_VINIT, OP_VEC,
        OP_FIN
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] step;
    } cmd_t;

    typedef struct packed {
        logic last_ray;
    } sts_t;

    function automatic logic signed [16:0] atan_lut(input logic [3:0] i);
        logic signed [16:0] v;
        case (i)
            4'd0:    v = 17'sd6434;
            4'd1:    v = 17'sd3798;
            4'd2:    v = 17'sd2007;
            4'd3:    v = 17'sd1019;
            4'd4:    v = 17'sd511;
            4'd5:    v = 17'sd256;
            4'd6:    v = 17'sd128;
            4'd7:    v = 17'sd64;
            4'd8:    v = 17'sd32;
            4'd9:    v = 17'sd16;
            4'd10:   v = 17'sd8;
            4'd11:   v = 17'sd4;
            4'd12:   v = 17'sd2;
            4'd13:   v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

    // Sigmoid of range, Q1.14, at quarter-metre knots
    function automatic logic [14:0] sig_lut(input logic [5:0] k);
        logic [14:0] v;
        case (k)
            6'd0:    v = 15'd1953;
            6'd1:    v = 15'd2989;
            6'd2:    v = 15'd4406;
            6'd3:    v = 15'd6186;
            6'd4:    v = 15'd8192;
            6'd5:    v = 15'd10198;
            6'd6:    v = 15'd11978;
            6'd7:    v = 15'd13395;
            6'd8:    v = 15'd14431;
            6'd9:    v = 15'd15141;
            6'd10:   v = 15'd15607;
            6'd11:   v = 15'd15904;
            6'd12:   v = 15'd16089;
            6'd13:   v = 15'd16204;
            6'd14:   v = 15'd16274;
            6'd15:   v = 15'd16317;
            6'd16:   v = 15'd16343;
            6'd17:   v = 15'd16359;
            6'd18:   v = 15'd16369;
            6'd19:   v = 15'd16375;
            6'd20:   v = 15'd16379;
            6'd21:   v = 15'd16381;
            6'd22:   v = 15'd16382;
            6'd23:   v = 15'd16383;
            6'd24:   v = 15'd16383;
            default: v = 15'd16384;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/lrs_ctrl.sv
// Sequencer for the lidar reactive steering block: one state per datapath operation.
// Depends on lrs_pkg.
`default_nettype none
module lrs_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire lrs_pkg::sts_t sts,
    output lrs_pkg::cmd_t     cmd
);

    lrs_pkg::state_t state_reg, state_next;
    logic [3:0]      step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lrs_pkg::ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd.op     = lrs_pkg::OP_NONE;
        cmd.step   = step_reg;
        unique case (state_reg)
            lrs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = lrs_pkg::OP_LOAD;
                    state_next = lrs_pkg::ST_ANG;
                end
            end
            lrs_pkg::ST_ANG: begin
                cmd.op     = lrs_pkg::OP_ANG;
                step_next  = 4'(lrs_pkg::RED_STEPS - 1);
                state_next = lrs_pkg::ST_RED;
            end
            lrs_pkg::ST_RED: begin
                cmd.op = lrs_pkg::OP_RED;
                if (step_reg == '0) begin
                    state_next = lrs_pkg::ST_FOLD;
                end else begin
                    step_next = step_reg - 4'd1;
                end
            end
            lrs_pkg::ST_FOLD: begin
                cmd.op     = lrs_pkg::OP_FOLD;
                step_next  = '0;
                state_next = lrs_pkg::ST_ROT;
            end
            lrs_pkg::ST_ROT: begin
                cmd.op = lrs_pkg::OP_ROT;
                if (step_reg == 4'(lrs_pkg::CORDIC_STEPS - 1)) begin
                    state_next = lrs_pkg::ST_SC;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            lrs_pkg::ST_SC: begin
                cmd.op     = lrs_pkg::OP_SC;
                state_next = lrs_pkg::ST_MCC;
            end
            lrs_pkg::ST_MCC: begin
                cmd.op     = lrs_pkg::OP_MCC;
                state_next = lrs_pkg::ST_MSS;
            end
            lrs_pkg::ST_MSS: begin
                cmd.op     = lrs_pkg::OP_MSS;
                state_next = lrs_pkg::ST_MINT;
            end
            lrs_pkg::ST_MINT: begin
                cmd.op     = lrs_pkg::OP_MINT;
                state_next = lrs_pkg::ST_MDW;
            end
            lrs_pkg::ST_MDW: begin
                cmd.op     = lrs_pkg::OP_MDW;
                state_next = lrs_pkg::ST_W;
            end
            lrs_pkg::ST_W: begin
                cmd.op     = lrs_pkg::OP_W;
                state_next = lrs_pkg::ST_MSW;
            end
            lrs_pkg::ST_MSW: begin
                cmd.op     = lrs_pkg::OP_MSW;
                state_next = lrs_pkg::ST_MCW;
            end
            lrs_pkg::ST_MCW: begin
                cmd.op     = lrs_pkg::OP_MCW;
                state_next = lrs_pkg::ST_MCOR;
            end
            lrs_pkg::ST_MCOR: begin
                cmd.op     = lrs_pkg::OP_MCOR;
                state_next = lrs_pkg::ST_UPD;
            end
            lrs_pkg::ST_UPD: begin
                cmd.op     = lrs_pkg::OP_UPD;
                state_next = sts.last_ray ? lrs_pkg::ST_VINIT : lrs_pkg::ST_IDLE;
            end
            lrs_pkg::ST_VINIT: begin
                cmd.op     = lrs_pkg::OP_VINIT;
                step_next  = '0;
                state_next = lrs_pkg::ST_VEC;
            end
            lrs_pkg::ST_VEC: begin
                cmd.op = lrs_pkg::OP_VEC;
                if (step_reg == 4'(lrs_pkg::CORDIC_STEPS - 1)) begin
                    state_next = lrs_pkg::ST_FIN;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            lrs_pkg::ST_FIN: begin
                cmd.op     = lrs_pkg::OP_FIN;
                state_next = lrs_pkg::ST_OUT;
            end
            lrs_pkg::ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = lrs_pkg::ST_IDLE;
                end
            end
            default: state_next = lrs_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/lrs_dp.sv
// Datapath for the lidar reactive steering block: config registers, shared multiplier,
// CORDIC rotation and vectoring, scan accumulators. Depends on lrs_pkg.
`default_nettype none
module lrs_dp #(
    parameter int MAX_RAYS = 1024
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [lrs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lrs_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic [15:0]                         s_ray_range,
    input  wire logic                                s_last_ray,
    input  wire lrs_pkg::cmd_t                       cmd,
    output lrs_pkg::sts_t                            sts,
    output logic [11:0]                              m_forward_speed,
    output logic signed [15:0]                       m_yaw_rate
);

    localparam int IDX_W = $clog2(MAX_RAYS);

    // configuration
    logic signed [15:0] start_reg;
    logic [13:0]        step_cfg_reg;
    logic [11:0]        chw_reg, radius_reg, speed_lim_reg;
    logic [8:0]         speed_db_reg;
    logic [13:0]        yaw_db_reg;
    logic [14:0]        yaw_lim_reg;

    // scan state
    logic signed [39:0] sine_sum_reg, cos_sum_reg;
    logic [15:0]        nearest_reg;
    logic [IDX_W-1:0]   idx_reg;

    // per-ray working registers
    logic [15:0]        r_reg;
    logic               last_reg;
    logic signed [35:0] prod_reg;
    logic signed [26:0] ang_reg;
    logic signed [17:0] x_reg, y_reg;
    logic signed [16:0] z_reg;
    logic               neg_reg;
    logic signed [16:0] s_reg, c_reg, dir_reg, w_reg;
    logic signed [35:0] cc_reg;
    logic signed [42:0] vx_reg, vy_reg;
    logic signed [17:0] vz_reg;
    logic [11:0]        speed_out_reg;
    logic signed [15:0] yaw_out_reg;

    logic signed [17:0] mul_a, mul_b;
    logic signed [26:0] ang_sum, red_val;
    logic signed [16:0] zf, atan_v, abs_s;
    logic signed [15:0] sig_diff;
    logic signed [17:0] sig_val;
    logic [5:0]         sig_k;
    logic signed [16:0] speed_raw;
    logic signed [17:0] yaw_abs, yaw_lim_s;
    logic [11:0]        speed_next;
    logic signed [15:0] yaw_next;
    logic               in_corridor;

    assign sts.last_ray    = last_reg;
    assign m_forward_speed = speed_out_reg;
    assign m_yaw_rate      = yaw_out_reg;

    always_comb begin
        ang_sum  = 27'(start_reg) + $signed(prod_reg[26:0]) + 27'(lrs_pkg::PI_Q13);
        red_val  = 27'(lrs_pkg::TWO_PI_Q13) <<< cmd.step;
        zf       = 17'(ang_reg - 27'(lrs_pkg::PI_Q13));
        atan_v   = lrs_pkg::atan_lut(cmd.step);
        abs_s    = s_reg[16] ? -s_reg : s_reg;
        sig_k    = {1'b0, r_reg[10:6]};
        sig_diff = $signed({1'b0, lrs_pkg::sig_lut(sig_k + 6'd1)})
                 - $signed({1'b0, lrs_pkg::sig_lut(sig_k)});
        sig_val  = (r_reg >= 16'(lrs_pkg::SIG_SAT_RANGE)) ? 18'(lrs_pkg::ONE_Q14)
                 : $signed({3'b0, lrs_pkg::sig_lut(sig_k)}) + 18'(prod_reg >>> 6);
        in_corridor = prod_reg <= $signed({10'b0, chw_reg, 14'b0});
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            lrs_pkg::OP_LOAD: begin
                mul_a = $signed(18'(idx_reg));
                mul_b = $signed(18'(step_cfg_reg));
            end
            lrs_pkg::OP_MCC: begin
                mul_a = 18'(c_reg);
                mul_b = 18'(c_reg);
            end
            lrs_pkg::OP_MSS: begin
                mul_a = 18'(s_reg);
                mul_b = 18'(s_reg);
            end
            lrs_pkg::OP_MINT: begin
                mul_a = 18'(sig_diff);
                mul_b = $signed({12'b0, r_reg[5:0]});
            end
            lrs_pkg::OP_MDW: begin
                mul_a = 18'(dir_reg);
                mul_b = sig_val;
            end
            lrs_pkg::OP_MSW: begin
                mul_a = 18'(s_reg);
                mul_b = 18'(w_reg);
            end
            lrs_pkg::OP_MCW: begin
                mul_a = 18'(c_reg);
                mul_b = 18'(w_reg);
            end
            lrs_pkg::OP_MCOR: begin
                mul_a = $signed({2'b0, r_reg});
                mul_b = 18'(abs_s);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // result formatting: deadband then clamp
    always_comb begin
        speed_raw = $signed({1'b0, nearest_reg}) - $signed({5'b0, radius_reg});
        if (speed_raw < $signed({8'b0, speed_db_reg})) begin
            speed_next = '0;
        end else if (speed_raw > $signed({5'b0, speed_lim_reg})) begin
            speed_next = speed_lim_reg;
        end else begin
            speed_next = speed_raw[11:0];
        end
        yaw_abs   = vz_reg[17] ? -vz_reg : vz_reg;
        yaw_lim_s = $signed({3'b0, yaw_lim_reg});
        if (yaw_abs < $signed({4'b0, yaw_db_reg})) begin
            yaw_next = '0;
        end else if (vz_reg > yaw_lim_s) begin
            yaw_next = 16'(yaw_lim_s);
        end else if (vz_reg < -yaw_lim_s) begin
            yaw_next = 16'(-yaw_lim_s);
        end else begin
            yaw_next = 16'(vz_reg);
        end
    end

    // configuration and scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg     <= -16'sd25736;
            step_cfg_reg  <= 14'd50;
            chw_reg       <= 12'd64;
            radius_reg    <= 12'd77;
            speed_db_reg  <= 9'd3;
            yaw_db_reg    <= 14'd410;
            speed_lim_reg <= 12'd256;
            yaw_lim_reg   <= 15'd8192;
            sine_sum_reg  <= '0;
            cos_sum_reg   <= '0;
            nearest_reg   <= 16'(lrs_pkg::NEAREST_RESET);
            idx_reg       <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    lrs_pkg::REG_START_ANGLE:    start_reg     <= $signed(cfg_wdata);
                    lrs_pkg::REG_ANGLE_STEP:     step_cfg_reg  <= cfg_wdata[13:0];
                    lrs_pkg::REG_CORRIDOR_HALF:  chw_reg       <= cfg_wdata[11:0];
                    lrs_pkg::REG_ROBOT_RADIUS:   radius_reg    <= cfg_wdata[11:0];
                    lrs_pkg::REG_SPEED_DEADBAND: speed_db_reg  <= cfg_wdata[8:0];
                    lrs_pkg::REG_YAW_DEADBAND:   yaw_db_reg    <= cfg_wdata[13:0];
                    lrs_pkg::REG_SPEED_LIMIT:    speed_lim_reg <= cfg_wdata[11:0];
                    lrs_pkg::REG_YAW_LIMIT:      yaw_lim_reg   <= cfg_wdata[14:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                lrs_pkg::OP_MCW:  sine_sum_reg <= sine_sum_reg + 40'(prod_reg >>> 14);
                lrs_pkg::OP_MCOR: cos_sum_reg  <= cos_sum_reg + 40'(prod_reg >>> 14);
                lrs_pkg::OP_UPD: begin
                    if (in_corridor && r_reg < nearest_reg) begin
                        nearest_reg <= r_reg;
                    end
                    if (!last_reg && idx_reg != IDX_W'(MAX_RAYS - 1)) begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                lrs_pkg::OP_FIN: begin
                    sine_sum_reg <= '0;
                    cos_sum_reg  <= '0;
                    nearest_reg  <= 16'(lrs_pkg::NEAREST_RESET);
                    idx_reg      <= '0;
                end
                default: ;
            endcase
        end
    end

    // per-ray working registers
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            lrs_pkg::OP_LOAD: begin
                r_reg    <= s_ray_range;
                last_reg <= s_last_ray;
            end
            lrs_pkg::OP_ANG: begin
                ang_reg <= ang_sum[26] ? ang_sum + 27'(lrs_pkg::TWO_PI_Q13) : ang_sum;
            end
            lrs_pkg::OP_RED: begin
                if (ang_reg >= red_val) begin
                    ang_reg <= ang_reg - red_val;
                end
            end
            lrs_pkg::OP_FOLD: begin
                x_reg <= 18'(lrs_pkg::CORDIC_X0);
                y_reg <= '0;
                if (zf > 17'(lrs_pkg::HALF_PI_Q13)) begin
                    z_reg   <= zf - 17'(lrs_pkg::PI_Q13);
                    neg_reg <= 1'b1;
                end else if (zf < -17'(lrs_pkg::HALF_PI_Q13)) begin
                    z_reg   <= zf + 17'(lrs_pkg::PI_Q13);
                    neg_reg <= 1'b1;
                end else begin
                    z_reg   <= zf;
                    neg_reg <= 1'b0;
                end
            end
            lrs_pkg::OP_ROT: begin
                if (!z_reg[16]) begin
                    x_reg <= x_reg - (y_reg >>> cmd.step);
                    y_reg <= y_reg + (x_reg >>> cmd.step);
                    z_reg <= z_reg - atan_v;
                end else begin
                    x_reg <= x_reg + (y_reg >>> cmd.step);
                    y_reg <= y_reg - (x_reg >>> cmd.step);
                    z_reg <= z_reg + atan_v;
                end
            end
            lrs_pkg::OP_SC: begin
                s_reg <= neg_reg ? 17'(-y_reg) : 17'(y_reg);
                c_reg <= neg_reg ? 17'(-x_reg) : 17'(x_reg);
            end
            lrs_pkg::OP_MSS:  cc_reg  <= prod_reg;
            lrs_pkg::OP_MINT: dir_reg <= 17'((cc_reg - prod_reg) >>> 15)
                                       + 17'(lrs_pkg::ONE_Q14);
            lrs_pkg::OP_W:    w_reg   <= 17'(prod_reg >>> 14);
            lrs_pkg::OP_VINIT: begin
                if (cos_sum_reg[39]) begin
                    vx_reg <= -43'(cos_sum_reg);
                    vy_reg <= -43'(sine_sum_reg);
                    vz_reg <= sine_sum_reg[39] ? -18'(lrs_pkg::PI_Q13)
                                               : 18'(lrs_pkg::PI_Q13);
                end else begin
                    vx_reg <= 43'(cos_sum_reg);
                    vy_reg <= 43'(sine_sum_reg);
                    vz_reg <= '0;
                end
            end
            lrs_pkg::OP_VEC: begin
                if (vy_reg > 43'sd0) begin
                    vx_reg <= vx_reg + (vy_reg >>> cmd.step);
                    vy_reg <= vy_reg - (vx_reg >>> cmd.step);
                    vz_reg <= vz_reg + 18'(atan_v);
                end else if (vy_reg < 43'sd0) begin
                    vx_reg <= vx_reg - (vy_reg >>> cmd.step);
                    vy_reg <= vy_reg + (vx_reg >>> cmd.step);
                    vz_reg <= vz_reg - 18'(atan_v);
                end
            end
            lrs_pkg::OP_FIN: begin
                speed_out_reg <= speed_next;
                yaw_out_reg   <= yaw_next;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/lidar_reactive_steering.sv
// Lidar reactive steering: top level, joins sequencer lrs_ctrl and datapath lrs_dp.
// Rays are taken one at a time; a ray goes through 11 modulo steps, 14 CORDIC
// rotations and 8 passes through the one shared 18x18 multiplier. A last ray adds
// atan2 vectoring; its result is held until taken. Reset (aresetn, synchronous,
// low) restores register defaults and clears the sums, nearest range and ray index.
`default_nettype none
`include "lidar_reactive_steering_defines.svh"
module lidar_reactive_steering #(
    parameter int MAX_RAYS = 1024
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration writes
    input  wire logic                           cfg_we,
    input  wire logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // ray input
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [15:0]                    s_ray_range,
    input  wire logic                           s_last_ray,
    // steering command output
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [11:0]                         m_forward_speed,
    output logic signed [15:0]                  m_yaw_rate
);

    lrs_pkg::cmd_t cmd;
    lrs_pkg::sts_t sts;

    // Sequencer: steps the datapath through one ray, then atan2 on the last one.
    lrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: angle reduction, sin/cos, weighting, sums, corridor minimum,
    // final deadband and clamp. Result registers hold steady while m_valid.
    lrs_dp #(
        .MAX_RAYS (MAX_RAYS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_ray_range     (s_ray_range),
        .s_last_ray      (s_last_ray),
        .cmd             (cmd),
        .sts             (sts),
        .m_forward_speed (m_forward_speed),
        .m_yaw_rate      (m_yaw_rate)
    );

    // One item in flight: no new ray while a result waits.
    `LRS_ASSERT_SAME(a_no_accept_with_result, aclk, aresetn, m_valid, !s_ready)
    // An accepted ray keeps the block busy for the following cycle.
    `LRS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A taken result is not shown again.
    `LRS_ASSERT_NEXT(a_single_result, aclk, aresetn, m_valid && m_ready, !m_valid)

endmodule
`default_nettype wire
